[hw/rtl/enat_pkg.sv]
// Shared types and constants for the earliest-arrival averaging block.
`default_nettype none
package enat_pkg;

	localparam int TIME_W = 32;
	localparam int PU_W   = 5;

	localparam logic [PU_W-1:0] PU_RESET = 5'd16;

	localparam logic [1:0] ACT_REC = 2'd0;
	localparam logic [1:0] ACT_RD  = 2'd1;
	localparam logic [1:0] ACT_CLR = 2'd2;

	typedef struct packed {
		logic wr;
		logic rd;
		logic clr;
	} mem_ctl_t;

endpackage
`default_nettype wire

[hw/rtl/earliest_n_arrival_time_average_top.sv]
// Top level: keeps the earliest n arrival times per side and returns their mean.
// Append of a photon while its side is not full: next transfer taken at once.
// Replacement in a full side: bound by a scan of the side memory, then one replacing write.
// Read: memory scan, then divider on the SW-bit sum, SW = 33 + log2(MAX_KEPT).
// Clear: next transfer taken at once. One item is worked on at a time; the result register frees the input.
// Reset: asynchronous, active low; lists empty, counts zero, photons_used 16.
`default_nettype none
module earliest_n_arrival_time_average_top
	import enat_pkg::*;
#(
	parameter int MAX_KEPT = 16
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_axis_tvalid,
	output logic                   s_axis_tready,
	input  wire logic [TIME_W-1:0] s_axis_tdata,  // arrival_time
	input  wire logic [2:0]        s_axis_tuser,  // action[1:0], side[2]
	output logic                   m_axis_tvalid,
	input  wire logic              m_axis_tready,
	output logic      [TIME_W-1:0] m_axis_tdata,  // average_time
	input  wire logic              cfg_we,
	input  wire logic [PU_W-1:0]   cfg_wdata
);

	localparam int AW = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
	localparam int CW = $clog2(MAX_KEPT + 1);
	localparam int SW = 33 + $clog2(MAX_KEPT);
	localparam int DW = CW + 1;
	localparam int PW = (CW > PU_W) ? CW : PU_W;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_SCAN  = 3'd1;
	localparam logic [2:0] ST_DRAIN = 3'd2;
	localparam logic [2:0] ST_REPL  = 3'd3;
	localparam logic [2:0] ST_DIVS  = 3'd4;
	localparam logic [2:0] ST_DIVW  = 3'd5;
	localparam logic [2:0] ST_OUT   = 3'd6;

	logic [2:0]        state_q;
	logic [PU_W-1:0]   pu_q;
	logic [CW-1:0]     count_l_q;
	logic [CW-1:0]     count_r_q;
	logic              pend_s1;
	logic              out_vld_q;
	logic [TIME_W-1:0] out_data_q;

	logic              side_q;
	logic [TIME_W-1:0] time_q;
	logic              op_rd_q;
	logic [AW-1:0]     idx_q;
	logic [AW-1:0]     ridx_s1;
	logic [TIME_W-1:0] max_q;
	logic [AW-1:0]     max_idx_q;
	logic [SW-1:0]     sum_q;

	logic [PW-1:0]     pu_ext;
	logic [CW-1:0]     n_eff;
	logic [1:0]        act;
	logic              side_in;
	logic              s_acc;
	logic [CW-1:0]     cnt_sel;
	logic              append;
	logic              repl_wr;
	logic              last;
	logic              out_load;
	logic [AW-1:0]     waddr;
	logic [TIME_W-1:0] wdata;
	mem_ctl_t          ctl_l;
	mem_ctl_t          ctl_r;
	logic [TIME_W-1:0] rd_l;
	logic [TIME_W-1:0] rd_r;
	logic [TIME_W-1:0] rd_sel;
	logic              div_done;
	logic [TIME_W-1:0] div_q;

	always_comb begin
		pu_ext = PW'(pu_q);
		if (pu_ext == '0) begin
			n_eff = CW'(1);
		end else if (pu_ext > PW'(MAX_KEPT)) begin
			n_eff = CW'(MAX_KEPT);
		end else begin
			n_eff = CW'(pu_ext);
		end
	end

	assign act      = s_axis_tuser[1:0];
	assign side_in  = s_axis_tuser[2];
	assign s_axis_tready = (state_q == ST_IDLE);
	assign s_acc    = s_axis_tvalid && s_axis_tready;
	assign cnt_sel  = side_in ? count_r_q : count_l_q;
	assign append   = s_acc && (act == ACT_REC) && (cnt_sel < n_eff);
	assign repl_wr  = (state_q == ST_REPL) && (max_q > time_q);
	assign last     = CW'(idx_q) == (n_eff - CW'(1));
	assign out_load = (state_q == ST_OUT) && (!out_vld_q || m_axis_tready);
	assign waddr    = (state_q == ST_REPL) ? max_idx_q : cnt_sel[AW-1:0];
	assign wdata    = (state_q == ST_REPL) ? time_q : s_axis_tdata;
	assign rd_sel   = side_q ? rd_r : rd_l;

	always_comb begin
		ctl_l.wr  = (append && !side_in) || (repl_wr && !side_q);
		ctl_r.wr  = (append && side_in) || (repl_wr && side_q);
		ctl_l.rd  = (state_q == ST_SCAN);
		ctl_r.rd  = (state_q == ST_SCAN);
		ctl_l.clr = s_acc && (act == ACT_CLR);
		ctl_r.clr = s_acc && (act == ACT_CLR);
	end

	enat_side_mem #(.DEPTH(MAX_KEPT), .AW(AW)) u_mem_l (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl_l),
		.waddr  (waddr),
		.wdata  (wdata),
		.raddr  (idx_q),
		.rdata  (rd_l)
	);

	enat_side_mem #(.DEPTH(MAX_KEPT), .AW(AW)) u_mem_r (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl_r),
		.waddr  (waddr),
		.wdata  (wdata),
		.raddr  (idx_q),
		.rdata  (rd_r)
	);

	enat_div #(.SW(SW), .DW(DW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (state_q == ST_DIVS),
		.dividend (sum_q),
		.divisor  ({n_eff, 1'b0}),
		.done     (div_done),
		.quotient (div_q)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			pu_q      <= PU_RESET;
			count_l_q <= '0;
			count_r_q <= '0;
			pend_s1   <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				pu_q <= cfg_wdata;
			end
			pend_s1 <= (state_q == ST_SCAN);
			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_vld_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_acc) begin
						case (act)
							ACT_REC: begin
								if (append) begin
									if (side_in) begin
										count_r_q <= count_r_q + CW'(1);
									end else begin
										count_l_q <= count_l_q + CW'(1);
									end
								end else begin
									state_q <= ST_SCAN;
								end
							end
							ACT_RD: begin
								state_q <= ST_SCAN;
							end
							ACT_CLR: begin
								count_l_q <= '0;
								count_r_q <= '0;
							end
							default: begin
							end
						endcase
					end
				end
				ST_SCAN: begin
					if (last) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= op_rd_q ? ST_DIVS : ST_REPL;
				end
				ST_REPL: begin
					state_q <= ST_IDLE;
				end
				ST_DIVS: begin
					state_q <= ST_DIVW;
				end
				ST_DIVW: begin
					if (div_done) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (s_acc) begin
			side_q  <= side_in;
			time_q  <= s_axis_tdata;
			op_rd_q <= (act == ACT_RD);
			idx_q   <= '0;
			sum_q   <= '0;
		end
		if (state_q == ST_SCAN) begin
			idx_q   <= idx_q + AW'(1);
			ridx_s1 <= idx_q;
		end
		if (pend_s1) begin
			if ((ridx_s1 == '0) || (rd_sel > max_q)) begin
				max_q     <= rd_sel;
				max_idx_q <= ridx_s1;
			end
			sum_q <= sum_q + SW'(rd_l) + SW'(rd_r);
		end
		if (out_load) begin
			out_data_q <= div_q;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = out_data_q;

endmodule
`default_nettype wire

[hw/rtl/enat_side_mem.sv]
// Time memory of one detector side with per-entry valid bits.
`default_nettype none
module enat_side_mem
	import enat_pkg::*;
#(
	parameter int DEPTH = 16,
	parameter int AW    = 4
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire mem_ctl_t          ctl,
	input  wire logic [AW-1:0]     waddr,
	input  wire logic [TIME_W-1:0] wdata,
	input  wire logic [AW-1:0]     raddr,
	output logic      [TIME_W-1:0] rdata
);

	logic [TIME_W-1:0] mem [DEPTH];
	logic [DEPTH-1:0]  valid_q;
	logic [TIME_W-1:0] mem_s1;
	logic              vld_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (ctl.clr) begin
			valid_q <= '0;
		end else if (ctl.wr) begin
			valid_q[waddr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.wr) begin
			mem[waddr] <= wdata;
		end
		if (ctl.rd) begin
			mem_s1 <= mem[raddr];
			vld_s1 <= valid_q[raddr];
		end
	end

	assign rdata = vld_s1 ? mem_s1 : '0;

endmodule
`default_nettype wire

[hw/rtl/enat_div.sv]
// Iterative restoring divider, one quotient bit per cycle.
`default_nettype none
module enat_div
	import enat_pkg::*;
#(
	parameter int SW = 37,
	parameter int DW = 6
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [SW-1:0]     dividend,
	input  wire logic [DW-1:0]     divisor,
	output logic                   done,
	output logic      [TIME_W-1:0] quotient
);

	localparam int NW = $clog2(SW + 1);

	logic          busy_q;
	logic          done_q;
	logic [NW-1:0] cnt_q;
	logic [DW-1:0] rem_q;
	logic [SW-1:0] quo_q;
	logic [DW-1:0] dvs_q;
	logic [DW:0]   trial;
	logic [DW:0]   diff;
	logic          ge;

	assign trial = {rem_q, quo_q[SW-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign ge    = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= NW'(SW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - NW'(1);
				if (cnt_q == NW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DW-1:0] : trial[DW-1:0];
			quo_q <= {quo_q[SW-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q[TIME_W-1:0];

endmodule
`default_nettype wire

[hw/rtl/enat_chk.sv]
// Port-level checker for the earliest-arrival averaging block and its bind.
`default_nettype none
module enat_chk
	import enat_pkg::*;
(
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              s_axis_tvalid,
	input wire logic              s_axis_tready,
	input wire logic [2:0]        s_axis_tuser,
	input wire logic              m_axis_tvalid,
	input wire logic              m_axis_tready,
	input wire logic [TIME_W-1:0] m_axis_tdata
);

	logic s_acc;

	assign s_acc = s_axis_tvalid && s_axis_tready;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
		else $error("result changed while stalled");

	a_read_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_acc && (s_axis_tuser[1:0] == ACT_RD) |=> !s_axis_tready && !$rose(m_axis_tvalid))
		else $error("read transfer did not start the averaging pass");

	a_clear_fast: assert property (@(posedge clk) disable iff (!arst_n)
		s_acc && (s_axis_tuser[1:0] == ACT_CLR) |=> s_axis_tready)
		else $error("clear transfer did not complete in one cycle");

endmodule

bind earliest_n_arrival_time_average_top enat_chk u_enat_chk (.*);
`default_nettype wire

[tb/sv/tb_top.sv]
// Testbench for the earliest-arrival averaging block: directed and random streams.
`default_nettype none
module tb_top;
	import enat_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int KEPT_MAX       = 16;
	localparam int SETTLE_CYCLES  = 80;
	localparam int STALL_LIMIT    = 4000;
	localparam logic [1:0] ACT_NONE = 2'd3;

	typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

	logic              clk           = 1'b0;
	logic              arst_n        = 1'b0;
	logic              s_axis_tvalid = 1'b0;
	logic              s_axis_tready;
	logic [TIME_W-1:0] s_axis_tdata  = '0;
	logic [2:0]        s_axis_tuser  = '0;
	logic              m_axis_tvalid;
	logic              m_axis_tready = 1'b0;
	logic [TIME_W-1:0] m_axis_tdata;
	logic              cfg_we        = 1'b0;
	logic [PU_W-1:0]   cfg_wdata     = '0;

	logic [TIME_W-1:0] kept_time [2][KEPT_MAX];
	int unsigned       kept_cnt [2];
	logic [PU_W-1:0]   photons_used;
	logic [TIME_W-1:0] pending_avg [$];
	logic [TIME_W-1:0] last_time = '0;

	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int err_cnt        = 0;
	int quiet_cycles   = 0;

	always #1 clk = ~clk;

	earliest_n_arrival_time_average_top #(
		.MAX_KEPT(KEPT_MAX)
	) u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata)
	);

	function automatic int unsigned eff_kept();
		if (photons_used < 1) return 1;
		if (photons_used > KEPT_MAX) return KEPT_MAX;
		return 32'(photons_used);
	endfunction

	task automatic clear_kept_times();
		for (int s = 0; s < 2; s++) begin
			kept_cnt[s] = 0;
			for (int i = 0; i < KEPT_MAX; i++) kept_time[s][i] = '0;
		end
	endtask

	task automatic update_kept_times(input logic [1:0] act, input logic sd,
			input logic [TIME_W-1:0] t);
		int unsigned n;
		int unsigned worst;
		logic [63:0] sum;
		n = eff_kept();
		case (act)
			ACT_REC: begin
				if (kept_cnt[sd] < n) begin
					kept_time[sd][kept_cnt[sd]] = t;
					if (kept_cnt[sd] < KEPT_MAX) kept_cnt[sd]++;
				end else begin
					worst = 0;
					for (int i = 1; i < n; i++)
						if (kept_time[sd][i] > kept_time[sd][worst]) worst = i;
					if (kept_time[sd][worst] > t) kept_time[sd][worst] = t;
				end
			end
			ACT_RD: begin
				sum = '0;
				for (int i = 0; i < n; i++)
					sum += 64'(kept_time[0][i]) + 64'(kept_time[1][i]);
				pending_avg.push_back(TIME_W'(sum / (64'(n) * 2)));
			end
			ACT_CLR: clear_kept_times();
			default: ;
		endcase
	endtask

	task automatic set_idle_mode(input idle_mode_t mode);
		send_idle_pct  = (mode == IDLE_SEND) ? 48 : (mode == IDLE_BOTH) ? 6 : 0;
		recv_stall_pct = (mode == IDLE_RECV) ? 48 : (mode == IDLE_BOTH) ? 6 : 0;
	endtask

	task automatic send_item(input logic [1:0] act, input logic sd,
			input logic [TIME_W-1:0] t);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= t;
		s_axis_tuser  <= {sd, act};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		update_kept_times(act, sd, t);
		last_time = t;
	endtask

	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_avg.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_photons_used(input logic [PU_W-1:0] v);
		wait_idle();
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		photons_used = v;
		cfg_we <= 1'b0;
	endtask

	function automatic logic [TIME_W-1:0] rand_time();
		case ($urandom_range(7))
			0:       return last_time;
			1:       return TIME_W'($urandom_range(2000));
			2:       return '1 - TIME_W'($urandom_range(2000));
			default: return TIME_W'($urandom);
		endcase
	endfunction

	task automatic test_directed();
		send_item(ACT_RD, 1'b0, '0);
		send_item(ACT_REC, 1'b0, '1);
		send_item(ACT_REC, 1'b1, '1);
		send_item(ACT_REC, 1'b0, '0);
		send_item(ACT_REC, 1'b1, '0);
		send_item(ACT_RD, 1'b1, '1);
		send_item(ACT_NONE, 1'b0, '1);
		send_item(ACT_NONE, 1'b1, '1);
		send_item(ACT_CLR, 1'b1, '1);
		send_item(ACT_RD, 1'b0, '0);
		set_photons_used(5'd0);
		send_item(ACT_REC, 1'b0, 32'd100);
		send_item(ACT_REC, 1'b0, 32'd50);
		send_item(ACT_REC, 1'b0, 32'd50);
		send_item(ACT_REC, 1'b0, 32'd70);
		send_item(ACT_REC, 1'b1, '1);
		send_item(ACT_RD, 1'b0, '0);
		set_photons_used(5'd2);
		send_item(ACT_REC, 1'b0, 32'd30);
		send_item(ACT_REC, 1'b0, 32'd30);
		send_item(ACT_REC, 1'b0, 32'd10);
		send_item(ACT_RD, 1'b0, '0);
		set_photons_used(5'd31);
		send_item(ACT_REC, 1'b1, 32'd5);
		send_item(ACT_RD, 1'b1, '0);
		set_photons_used(5'd1);
		send_item(ACT_RD, 1'b0, '0);
		send_item(ACT_CLR, 1'b0, '0);
	endtask

	task automatic run_events(input int n_items);
		int sent;
		int burst;
		sent = 0;
		while (sent < n_items) begin
			if ($urandom_range(9) < 8) begin
				send_item(ACT_CLR, 1'($urandom_range(1)), rand_time());
				burst = $urandom_range(40);
				for (int k = 0; k < burst; k++) begin
					send_item(ACT_REC, 1'($urandom_range(1)), rand_time());
					if ($urandom_range(19) == 0) begin
						send_item(ACT_RD, 1'($urandom_range(1)), rand_time());
						sent++;
					end
				end
				send_item(ACT_RD, 1'($urandom_range(1)), rand_time());
				sent += burst + 2;
			end else begin
				for (int k = 0; k < 5; k++)
					send_item(2'($urandom_range(3)), 1'($urandom_range(1)), rand_time());
				sent += 5;
			end
		end
	endtask

	task automatic test_random(input idle_mode_t mode, input logic [PU_W-1:0] pu_a,
			input logic [PU_W-1:0] pu_b);
		wait_idle();
		set_idle_mode(mode);
		set_photons_used(pu_a);
		run_events(100);
		set_photons_used(pu_b);
		run_events(100);
	endtask

	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		logic [TIME_W-1:0] exp_avg;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_avg.size() == 0) begin
				$display("%0t: unexpected average, expected none, got %h", $time, m_axis_tdata);
				err_cnt++;
			end else begin
				exp_avg = pending_avg.pop_front();
				if (m_axis_tdata !== exp_avg) begin
					$display("%0t: average mismatch, expected %h, got %h",
						$time, exp_avg, m_axis_tdata);
					err_cnt++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("tb_top: done, errors");
			$finish;
		end
	end

	initial begin
		clear_kept_times();
		photons_used = PU_RESET;
		set_idle_mode(IDLE_NONE);
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(IDLE_NONE, 5'd16, 5'd3);
		test_random(IDLE_SEND, 5'd31, 5'd1);
		test_random(IDLE_RECV, 5'd0, PU_W'($urandom_range(1, 15)));
		test_random(IDLE_BOTH, PU_W'($urandom_range(31)), 5'd8);
		wait_idle();
		if (err_cnt == 0 && pending_avg.size() == 0) begin
			$display("tb_top: done, clean");
		end else begin
			$display("tb_top: done, errors");
		end
		$finish;
	end

endmodule
`default_nettype wire

[filelist.f]
hw/rtl/enat_pkg.sv
hw/rtl/enat_side_mem.sv
hw/rtl/enat_div.sv
hw/rtl/earliest_n_arrival_time_average_top.sv
hw/rtl/enat_chk.sv
tb/sv/tb_top.sv
